>>> rtl/im2col_tile_address_generator_top_macros.svh
// Assertion macros for the im2col tile address generator.
`ifndef IM2COL_TILE_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define IM2COL_TILE_ADDRESS_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define I2C_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("im2col address generator check failed");
// Next-cycle implication, checked outside reset.
`define I2C_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("im2col address generator check failed");
`else
`define I2C_ASSERT_NOW(label, clk, rst, ante, cons)
`define I2C_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/im2col_tag_pkg.sv
// Shared constants and types for the im2col tile address generator.
package im2col_tag_pkg;

  // Fixed layout constants
  localparam int TILE_PIXELS = 16;
  localparam int GROUP_WIDTH = 4;

  // Parameter defaults
  localparam int DEF_DILATION_ROWS = 1;
  localparam int DEF_DILATION_COLS = 1;
  localparam int DEF_MAX_GROUPS    = 16;

  // Field widths
  localparam int PIX_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int TAP_W   = 3;
  localparam int TNUM_W  = 6;
  localparam int SRC_W   = 22;
  localparam int DST_W   = 16;
  localparam int DIM_W   = 9;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 3;

  // Shared multiply-add widths
  localparam int MAC_A_W = 18;
  localparam int MAC_B_W = 9;
  localparam int MAC_C_W = 10;
  localparam int MAC_R_W = 28;

  // Divider step count
  localparam int DIV_STEPS = PIX_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_HEIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd7;

  // Operands for the shared multiply-add: a * b + c
  typedef struct packed {
    logic [MAC_A_W-1:0]        a;
    logic [MAC_B_W-1:0]        b;
    logic signed [MAC_C_W-1:0] c;
  } mac_req_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/im2col_tag_if.sv
// Valid/ready channel interfaces for input items and result words.
interface im2col_tag_in_if;
  import im2col_tag_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_index;
  logic [SLOT_W-1:0] tile_slot;
  logic [TAP_W-1:0]  tap_row;
  logic [TAP_W-1:0]  tap_col;
  logic [TNUM_W-1:0] tap_number;

  modport source (output valid, pixel_index, tile_slot, tap_row, tap_col, tap_number,
                  input ready);
  modport sink (input valid, pixel_index, tile_slot, tap_row, tap_col, tap_number,
                output ready);
endinterface

interface im2col_tag_out_if;
  import im2col_tag_pkg::*;

  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] source_offset;
  logic [DST_W-1:0] dest_offset;
  logic             in_bounds;
  logic             last_group;

  modport source (output valid, source_offset, dest_offset, in_bounds, last_group,
                  input ready);
  modport sink (input valid, source_offset, dest_offset, in_bounds, last_group,
                output ready);
endinterface

>>> rtl/im2col_tag_div.sv
// Restoring divider, one quotient bit per cycle.
module im2col_tag_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [im2col_tag_pkg::PIX_W-1:0]   dividend,
  input  logic [im2col_tag_pkg::DIM_W-1:0]   divisor,
  output logic [im2col_tag_pkg::PIX_W-1:0]   quotient,
  output logic [im2col_tag_pkg::DIM_W-1:0]   remainder,
  output im2col_tag_pkg::div_stat_t          stat
);
  import im2col_tag_pkg::*;

  logic [PIX_W-1:0]     work;
  logic [DIM_W-1:0]     rem;
  logic [DIM_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIM_W:0]       rem_sh;
  logic [DIM_W:0]       diff;
  logic                 ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    rem_sh = {rem, work[PIX_W-1]};
    ge     = rem_sh >= {1'b0, dsr};
    diff   = rem_sh - {1'b0, dsr};
  end

  // Control: count steps, flag the finish
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one quotient bit a step
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      work <= {work[PIX_W-2:0], ge};
      rem  <= ge ? diff[DIM_W-1:0] : rem_sh[DIM_W-1:0];
    end
  end

  assign quotient  = work;
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> rtl/im2col_tag_mac.sv
// Shared multiply-add unit with a registered result: a * b + c.
module im2col_tag_mac (
  input  logic                                   clk,
  input  im2col_tag_pkg::mac_req_t               req,
  output logic signed [im2col_tag_pkg::MAC_R_W-1:0] res
);
  import im2col_tag_pkg::*;

  logic [MAC_A_W+MAC_B_W-1:0] prod;

  // Unsigned product, then signed offset
  always_comb begin
    prod = req.a * req.b;
  end

  always_ff @(posedge clk) begin
    res <= $signed({1'b0, prod}) + {{(MAC_R_W-MAC_C_W){req.c[MAC_C_W-1]}}, req.c};
  end

endmodule

>>> rtl/im2col_tile_address_generator_top.sv
// Top level of the im2col tile address generator: registers, sequencer, result stage.
//
//   channel  dir  handshake          payload
//   item     in   valid/ready        pixel_index, tile_slot, tap_row, tap_col, tap_number
//   result   out  valid/ready        source_offset, dest_offset, in_bounds, last_group
//   cfg      in   cfg_wr_en (write)  cfg_index, cfg_wr_data
//
// An item is accepted, passes through the bit-serial divider (pixel index by output width),
// then makes five passes through the shared multiply-add (registered, so each pass's result
// is used by the next state), then one word per cycle leaves the result register while the
// result channel is ready. A tap in padding skips the last pass and gives its single word.
// An item with zero channel groups is dropped at acceptance. Reset is synchronous and
// clears all control state. A stalled result word holds in its register while the next
// item is taken in.
`include "im2col_tile_address_generator_top_macros.svh"

module im2col_tile_address_generator_top #(
  parameter int DILATION_ROWS = im2col_tag_pkg::DEF_DILATION_ROWS,
  parameter int DILATION_COLS = im2col_tag_pkg::DEF_DILATION_COLS,
  parameter int MAX_GROUPS    = im2col_tag_pkg::DEF_MAX_GROUPS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  im2col_tag_in_if.sink                          item,
  im2col_tag_out_if.source                       result,
  input  logic                                   cfg_wr_en,
  input  logic [im2col_tag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [im2col_tag_pkg::CFG_W-1:0]       cfg_wr_data
);
  import im2col_tag_pkg::*;

  localparam int GRP_W  = 5;
  localparam int TSUM_W = DST_W - SLOT_W - $clog2(GROUP_WIDTH);
  localparam int SSUM_W = SRC_W - $clog2(GROUP_WIDTH);
  localparam int GW_SH  = $clog2(GROUP_WIDTH);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV  = 4'd1;
  localparam logic [3:0] ST_MY   = 4'd2;
  localparam logic [3:0] ST_MX   = 4'd3;
  localparam logic [3:0] ST_MD   = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_MS1  = 4'd6;
  localparam logic [3:0] ST_MS2  = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  // Configuration registers
  logic [3:0]       stride_rows, stride_cols, pad_rows, pad_cols;
  logic [DIM_W-1:0] input_height, input_width, output_width;
  logic [6:0]       channel_count;

  // Sequencer and item registers
  logic [3:0]        state;
  logic [PIX_W-1:0]  pix;
  logic [SLOT_W-1:0] slot;
  logic [TAP_W-1:0]  trow, tcol;
  logic [TNUM_W-1:0] tnum;
  logic signed [MAC_R_W-1:0] y, x;
  logic [TSUM_W-1:0] tprod;
  logic [SSUM_W-1:0] sprod;
  logic              oob;
  logic [GRP_W-1:0]  g;

  // Result register
  logic             res_valid;
  logic [SRC_W-1:0] res_src;
  logic [DST_W-1:0] res_dst;
  logic             res_inb;
  logic             res_last;

  // Unit hookup
  logic [PIX_W-1:0]          quot;
  logic [DIM_W-1:0]          rem;
  div_stat_t                 div_stat;
  mac_req_t                  mac_req;
  logic signed [MAC_R_W-1:0] mac_res;

  logic                item_acc;
  logic [7:0]          grp_sum;
  logic [GRP_W:0]      grp_raw;
  logic [GRP_W-1:0]    groups;
  logic [PIX_W-1:0]    prow, pcol;
  logic [5:0]          trow_dil, tcol_dil;
  logic                oob_now;
  logic                load;
  logic                last_now;
  logic [TSUM_W-1:0]   tsum;
  logic [SSUM_W-1:0]   ssum;

  // Group count, saturated
  always_comb begin
    grp_sum = {1'b0, channel_count} + 8'(GROUP_WIDTH - 1);
    grp_raw = grp_sum[GRP_W+2:2];
    groups  = (grp_raw > (GRP_W+1)'(MAX_GROUPS)) ? GRP_W'(MAX_GROUPS) : grp_raw[GRP_W-1:0];
  end

  assign item_acc   = item.valid && item.ready;
  assign item.ready = (state == ST_IDLE);

  // Zero output width leaves row 0 and the whole index as column
  assign prow = (output_width == '0) ? '0  : quot;
  assign pcol = (output_width == '0) ? pix : {{(PIX_W-DIM_W){1'b0}}, rem};

  assign trow_dil = 6'(trow) * 6'(DILATION_ROWS);
  assign tcol_dil = 6'(tcol) * 6'(DILATION_COLS);

  // Bounds check on the tap position
  assign oob_now = y[MAC_R_W-1] || (y[MAC_R_W-2:0] >= (MAC_R_W-1)'(input_height)) ||
                   x[MAC_R_W-1] || (x[MAC_R_W-2:0] >= (MAC_R_W-1)'(input_width));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stride_rows   <= 4'd1;
      stride_cols   <= 4'd1;
      pad_rows      <= 4'd0;
      pad_cols      <= 4'd0;
      input_height  <= DIM_W'(1);
      input_width   <= DIM_W'(1);
      output_width  <= DIM_W'(1);
      channel_count <= 7'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_STRIDE_ROWS:   stride_rows   <= cfg_wr_data[3:0];
        REG_STRIDE_COLS:   stride_cols   <= cfg_wr_data[3:0];
        REG_PAD_ROWS:      pad_rows      <= cfg_wr_data[3:0];
        REG_PAD_COLS:      pad_cols      <= cfg_wr_data[3:0];
        REG_INPUT_HEIGHT:  input_height  <= cfg_wr_data[DIM_W-1:0];
        REG_INPUT_WIDTH:   input_width   <= cfg_wr_data[DIM_W-1:0];
        REG_OUTPUT_WIDTH:  output_width  <= cfg_wr_data[DIM_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_wr_data[6:0];
        default: ;
      endcase
    end
  end

  im2col_tag_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (item_acc && (groups != '0)),
    .dividend  (item.pixel_index),
    .divisor   (output_width),
    .quotient  (quot),
    .remainder (rem),
    .stat      (div_stat)
  );

  // Operand select for the shared multiply-add
  always_comb begin
    mac_req = '0;
    case (state)
      ST_MY: begin
        mac_req.a = MAC_A_W'(prow);
        mac_req.b = MAC_B_W'(stride_rows);
        mac_req.c = $signed(MAC_C_W'(trow_dil) - MAC_C_W'(pad_rows));
      end
      ST_MX: begin
        mac_req.a = MAC_A_W'(pcol);
        mac_req.b = MAC_B_W'(stride_cols);
        mac_req.c = $signed(MAC_C_W'(tcol_dil) - MAC_C_W'(pad_cols));
      end
      ST_MD: begin
        mac_req.a = MAC_A_W'(tnum);
        mac_req.b = MAC_B_W'(groups);
      end
      ST_CHK: begin
        mac_req.a = MAC_A_W'(y[DIM_W-1:0]);
        mac_req.b = input_width;
        mac_req.c = $signed(MAC_C_W'(x[DIM_W-1:0]));
      end
      ST_MS1: begin
        mac_req.a = mac_res[MAC_A_W-1:0];
        mac_req.b = MAC_B_W'(groups);
      end
      default: ;
    endcase
  end

  im2col_tag_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .res (mac_res)
  );

  // Result word for group g
  assign load     = (state == ST_EMIT) && (!res_valid || result.ready);
  assign last_now = oob || ((g + 1'b1) == groups);
  assign tsum     = tprod + TSUM_W'(g);
  assign ssum     = sprod + SSUM_W'(g);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (item_acc && (groups != '0)) state <= ST_DIV;
        ST_DIV:  if (div_stat.done) state <= ST_MY;
        ST_MY:   state <= ST_MX;
        ST_MX:   state <= ST_MD;
        ST_MD:   state <= ST_CHK;
        ST_CHK:  state <= oob_now ? ST_EMIT : ST_MS1;
        ST_MS1:  state <= ST_MS2;
        ST_MS2:  state <= ST_EMIT;
        ST_EMIT: if (load && last_now) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold item fields and intermediate values
  always_ff @(posedge clk) begin
    if (item_acc) begin
      pix  <= item.pixel_index;
      slot <= item.tile_slot;
      trow <= item.tap_row;
      tcol <= item.tap_col;
      tnum <= item.tap_number;
    end
    case (state)
      ST_MX:  y <= mac_res;
      ST_MD:  x <= mac_res;
      ST_CHK: begin
        tprod <= mac_res[TSUM_W-1:0];
        oob   <= oob_now;
        g     <= '0;
      end
      ST_MS2: sprod <= mac_res[SSUM_W-1:0];
      ST_EMIT: if (load) g <= g + 1'b1;
      default: ;
    endcase
  end

  // Result register: load a word, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_src  <= oob ? '0 : {ssum, {GW_SH{1'b0}}};
      res_dst  <= {tsum, slot, {GW_SH{1'b0}}};
      res_inb  <= !oob;
      res_last <= last_now;
    end
  end

  assign result.valid         = res_valid;
  assign result.source_offset = res_src;
  assign result.dest_offset   = res_dst;
  assign result.in_bounds     = res_inb;
  assign result.last_group    = res_last;

  // Checks
  `I2C_ASSERT_NOW(a_pad_word_single, clk, rst, result.valid && !result.in_bounds, result.last_group && (result.source_offset == '0))
  `I2C_ASSERT_NOW(a_group_in_range, clk, rst, state == ST_EMIT, g < groups)
  `I2C_ASSERT_NOW(a_div_only_in_div, clk, rst, div_stat.busy || div_stat.done, state == ST_DIV)
  `I2C_ASSERT_NEXT(a_accept_starts_div, clk, rst, item_acc && (groups != '0), state == ST_DIV)

endmodule
